// ===== sv/bsum_pkg.sv =====
// ----------------------------------------------------------------------------
// bsum_pkg
// Shared types, field widths and constants for the 2x2 wrapping box sum.
// ----------------------------------------------------------------------------
package bsum_pkg;

  localparam int MAX_LINE_DEF = 2048;

  localparam int FW_W   = 12;
  localparam int FH_W   = 16;
  localparam int ROW_W  = 16;
  localparam int COL_W  = 11;
  localparam int CH_W   = 8;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_FIELD_W = ROW_W + COL_W + 3 * CH_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  localparam int OUT_FIFO_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic row_end;
    logic last_row;
  } scan_flags_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    pixel_t           sum;
    logic             run_last;
    logic             frame_last;
  } result_t;

  // Per-channel add, each channel wrapping at 256.
  function automatic pixel_t pix_add(pixel_t a, pixel_t b);
    pixel_t s;
    s.red   = a.red + b.red;
    s.green = a.green + b.green;
    s.blue  = a.blue + b.blue;
    return s;
  endfunction

endpackage

// ===== sv/bsum_scan.sv =====
// ----------------------------------------------------------------------------
// bsum_scan
// Frame size registers and the raster position of the next input pixel.
// ----------------------------------------------------------------------------
module bsum_scan #(
  parameter int MAX_LINE = bsum_pkg::MAX_LINE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [bsum_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bsum_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                advance,
  output logic [$clog2(MAX_LINE)-1:0]         x,
  output logic [bsum_pkg::ROW_W-1:0]          y,
  output bsum_pkg::scan_flags_t               flags
);
  import bsum_pkg::*;

  localparam int XW = $clog2(MAX_LINE);
  localparam int LW = $clog2(MAX_LINE + 1);

  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;
  logic [XW-1:0]    col_count;
  logic [ROW_W-1:0] row_count;
  logic [LW-1:0]    w_eff;
  logic [LW-1:0]    w_last;
  logic [FH_W-1:0]  h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero size acts as one, and a width beyond the line store is clipped.
  always_comb begin
    if (frame_width == '0) begin
      w_eff = LW'(1);
    end else if (32'(frame_width) > 32'(MAX_LINE)) begin
      w_eff = LW'(MAX_LINE);
    end else begin
      w_eff = LW'(frame_width);
    end
    w_last = w_eff - LW'(1);
    h_eff  = (frame_height == '0) ? FH_W'(1) : frame_height;
  end

  // A column left beyond a narrowed width is taken as the last column.
  assign x              = (LW'(col_count) >= w_eff) ? XW'(w_last) : col_count;
  assign y              = row_count;
  assign flags.row_end  = (LW'(x) == w_last);
  assign flags.last_row = (row_count >= h_eff - FH_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (advance) begin
      if (flags.row_end) begin
        col_count <= '0;
        row_count <= flags.last_row ? '0 : row_count + ROW_W'(1);
      end else begin
        col_count <= x + XW'(1);
      end
    end
  end

endmodule

// ===== sv/bsum_line_buf.sv =====
// ----------------------------------------------------------------------------
// bsum_line_buf
// One line of the previous row, read and written at the same column per beat.
// ----------------------------------------------------------------------------
module bsum_line_buf #(
  parameter int MAX_LINE = bsum_pkg::MAX_LINE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        access,
  input  logic [$clog2(MAX_LINE)-1:0] addr,
  input  bsum_pkg::pixel_t            wdata,
  output bsum_pkg::pixel_t            rdata
);
  import bsum_pkg::*;

  localparam int LW = $clog2(MAX_LINE + 1);

  pixel_t        mem [MAX_LINE];
  pixel_t        rd_q;
  logic          rd_hit;
  logic [LW-1:0] fill;

  // Read-first: the beat sees the value the previous row left at this column.
  always_ff @(posedge clk) begin
    if (access) begin
      mem[addr] <= wdata;
      rd_q      <= mem[addr];
    end
  end

  // Columns are always written as a prefix from zero upwards, so a fill count
  // tells which entries have not been written since reset and so read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      rd_hit <= 1'b0;
    end else if (access) begin
      rd_hit <= (LW'(addr) < fill);
      if (LW'(addr) == fill) begin
        fill <= fill + LW'(1);
      end
    end
  end

  assign rdata = rd_hit ? rd_q : '0;

endmodule

// ===== sv/bsum_window.sv =====
// ----------------------------------------------------------------------------
// bsum_window
// Window register and result sequencer: forms up to four sums per pixel.
// ----------------------------------------------------------------------------
module bsum_window #(
  parameter int MAX_LINE = bsum_pkg::MAX_LINE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  bsum_pkg::pixel_t            cur,
  input  logic [$clog2(MAX_LINE)-1:0] x,
  input  logic [bsum_pkg::ROW_W-1:0]  y,
  input  bsum_pkg::scan_flags_t       flags,
  input  bsum_pkg::pixel_t            up,
  input  logic                        can_push,
  output logic                        ready,
  output logic                        push,
  output bsum_pkg::result_t           res
);
  import bsum_pkg::*;

  localparam int XW = $clog2(MAX_LINE);

  // Pending result kinds, in emission order.
  localparam int WIN_FULL   = 0;
  localparam int WIN_RIGHT  = 1;
  localparam int WIN_BOTTOM = 2;
  localparam int WIN_CORNER = 3;

  logic             s1_valid;
  logic [3:0]       pending;
  logic [3:0]       sel;
  logic             single;
  logic             done;
  pixel_t           left_pixel;
  pixel_t           cur_q;
  pixel_t           left_q;
  pixel_t           ul_q;
  logic [XW-1:0]    x_q;
  logic [ROW_W-1:0] y_q;
  logic             x_nz;
  logic             y_nz;

  assign x_nz = (x != '0);
  assign y_nz = (y != '0);

  assign sel    = pending & (~pending + 4'd1);
  assign single = ((pending & (pending - 4'd1)) == 4'd0);
  assign done   = (pending == 4'd0) || (single && can_push);
  assign ready  = !s1_valid || done;
  assign push   = s1_valid && (pending != 4'd0) && can_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      pending    <= '0;
      left_pixel <= '0;
    end else if (load) begin
      s1_valid               <= 1'b1;
      pending[WIN_FULL]      <= y_nz && x_nz;
      pending[WIN_RIGHT]     <= y_nz && flags.row_end;
      pending[WIN_BOTTOM]    <= flags.last_row && x_nz;
      pending[WIN_CORNER]    <= flags.last_row && flags.row_end;
      left_pixel             <= cur;
    end else begin
      if (push) begin
        pending <= pending & ~sel;
      end
      if (s1_valid && done) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // The upper-left pixel is the line read of the beat before, still held at
  // the line store output when the next beat is taken.
  always_ff @(posedge clk) begin
    if (load) begin
      cur_q  <= cur;
      left_q <= left_pixel;
      ul_q   <= up;
      x_q    <= x;
      y_q    <= y;
    end
  end

  always_comb begin
    res = '0;
    if (sel[WIN_FULL]) begin
      res.sum = pix_add(pix_add(ul_q, up), pix_add(left_q, cur_q));
    end else if (sel[WIN_RIGHT]) begin
      res.sum = pix_add(up, cur_q);
    end else if (sel[WIN_BOTTOM]) begin
      res.sum = pix_add(left_q, cur_q);
    end else begin
      res.sum = cur_q;
    end
    res.row = (sel[WIN_BOTTOM] || sel[WIN_CORNER]) ? y_q : y_q - ROW_W'(1);
    res.col = (sel[WIN_FULL] || sel[WIN_BOTTOM]) ? COL_W'(x_q - XW'(1)) : COL_W'(x_q);
    res.run_last   = ((pending & ~sel) == 4'd0);
    res.frame_last = sel[WIN_CORNER];
  end

endmodule

// ===== sv/bsum_out_fifo.sv =====
// ----------------------------------------------------------------------------
// bsum_out_fifo
// Small result queue that soaks up last-row bursts and parts the two sides.
// ----------------------------------------------------------------------------
module bsum_out_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bsum_pkg::result_t  push_data,
  output logic               can_push,
  output logic               valid,
  input  logic               pop_ready,
  output bsum_pkg::result_t  head
);
  import bsum_pkg::*;

  localparam int PW = $clog2(OUT_FIFO_DEPTH);
  localparam int CW = $clog2(OUT_FIFO_DEPTH + 1);

  result_t       slots [OUT_FIFO_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          pop;

  assign valid    = (count != '0);
  assign pop      = valid && pop_ready;
  assign can_push = (count < CW'(OUT_FIFO_DEPTH));
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(OUT_FIFO_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(OUT_FIFO_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== sv/box_sum_2x2_wrapping_unit.sv =====
// ----------------------------------------------------------------------------
// box_sum_2x2_wrapping_unit
// 2x2 box sum over an RGB raster stream, channels wrapping at 256.
// ----------------------------------------------------------------------------
//  Channel  | Beat                                   | Sideband
//  s_axis   | one pixel: red, green, blue            | none
//  m_axis   | row, column and window sums of a pixel | tlast: last of a pixel's
//           |                                        | results; tuser: frame end
//  cfg      | frame_width (0), frame_height (1)      | write only
//
// A pixel with at most one result is taken every cycle while the queue has room.
// A pixel with more results (up to four, more than one only at a row end or on
// the last row) keeps the window register until all are pushed, one result a
// cycle while there is room, and the next pixel is taken with the last of them.
// Results enter a four-deep queue whose head is on m_axis; output stalls hold the
// input back only once the queue fills. Reset is synchronous, no clearing pass.
// ----------------------------------------------------------------------------
module box_sum_2x2_wrapping_unit #(
  parameter int MAX_LINE = bsum_pkg::MAX_LINE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] in_red, [15:8] in_green, [23:16] in_blue
  input  logic [bsum_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [15:0] out_row, [26:16] out_col, [34:27] sum_red, [42:35] sum_green,
  // [50:43] sum_blue, [55:51] zero
  output logic [bsum_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tlast,
  // [0] frame_last
  output logic                                m_axis_tuser,
  input  logic                                cfg_write,
  input  logic [bsum_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bsum_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bsum_pkg::*;

  localparam int XW = $clog2(MAX_LINE);

  logic             in_accept;
  pixel_t           cur;
  logic [XW-1:0]    x;
  logic [ROW_W-1:0] y;
  scan_flags_t      flags;
  pixel_t           up;
  logic             can_push;
  logic             push;
  result_t          res;
  result_t          head;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign cur.red   = s_axis_tdata[7:0];
  assign cur.green = s_axis_tdata[15:8];
  assign cur.blue  = s_axis_tdata[23:16];

  bsum_scan #(.MAX_LINE(MAX_LINE)) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (in_accept),
    .x         (x),
    .y         (y),
    .flags     (flags)
  );

  bsum_line_buf #(.MAX_LINE(MAX_LINE)) u_line_buf (
    .clk    (clk),
    .rst    (rst),
    .access (in_accept),
    .addr   (x),
    .wdata  (cur),
    .rdata  (up)
  );

  bsum_window #(.MAX_LINE(MAX_LINE)) u_window (
    .clk      (clk),
    .rst      (rst),
    .load     (in_accept),
    .cur      (cur),
    .x        (x),
    .y        (y),
    .flags    (flags),
    .up       (up),
    .can_push (can_push),
    .ready    (s_axis_tready),
    .push     (push),
    .res      (res)
  );

  bsum_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .can_push  (can_push),
    .valid     (m_axis_tvalid),
    .pop_ready (m_axis_tready),
    .head      (head)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, head.sum.blue, head.sum.green, head.sum.red,
                         head.col, head.row};
  assign m_axis_tlast = head.run_last;
  assign m_axis_tuser = head.frame_last;

endmodule
